/* src/afisc_pkg.sv */
// ----------------------------------------------------------------------------
// afisc_pkg: shared types and constants for the audio sample converter
// Beat payloads, pipeline advance controls, register map and format limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afisc_pkg;

   typedef struct packed {
      logic        mode;
      logic [31:0] sample_in;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [31:0] sample_out;
      logic        last_out;
   } rsp_type;

   // Per-stage load enables; a stage loads whenever it is empty or drains.
   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
   } adv_type;

   localparam logic MODE_F2I = 1'b0;
   localparam logic MODE_I2F = 1'b1;

   localparam logic REG_WIDTH_SEL = 1'b0;

   localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
   localparam logic [31:0] MAX16 = 32'h0000_7FFF;

   // Leading zero count of a 32-bit word (all zeros gives 0, caller checks).
   function automatic logic [4:0] lead_zeros(input logic [31:0] w);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (w[i]) begin
            n = 5'(31 - i);
         end
      end
      return n;
   endfunction

endpackage

/* src/afisc_pipe.sv */
// ----------------------------------------------------------------------------
// afisc_pipe: three-stage conversion datapath
// Stage 1 decodes and forms the exact scaled product, stage 2 normalizes or
// rounds to float precision, stage 3 rounds, clips and packs the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afisc_pipe (
   input  logic               clock,
   input  afisc_pkg::adv_type adv,
   input  afisc_pkg::req_type req,
   input  logic               narrow,
   output afisc_pkg::rsp_type rsp
);

   // Stage 1 registers
   logic        s1_mode_ff, s1_narrow_ff, s1_last_ff, s1_sign_ff;
   logic        s1_nan_ff, s1_big_ff, s1_tiny_ff;
   logic [38:0] s1_prod_ff;
   logic [7:0]  s1_expo_ff;
   logic        s1_sign_in, s1_nan_in, s1_big_in, s1_tiny_in;
   logic [38:0] s1_prod_in;

   // Stage 2 registers
   logic        s2_mode_ff, s2_narrow_ff, s2_last_ff, s2_sign_ff;
   logic        s2_nan_ff, s2_big_ff, s2_tiny_ff, s2_zero_ff;
   logic [31:0] s2_mant_ff;
   logic [7:0]  s2_expo_ff;
   logic [6:0]  s2_shift_ff;
   logic [31:0] s2_mant_in;
   logic [7:0]  s2_expo_in;
   logic [6:0]  s2_shift_in;

   // Stage 3 (output) register
   afisc_pkg::rsp_type s3_rsp_ff, s3_rsp_in;

   // ---------------- stage 1 ----------------
   logic [31:0] ival, mag;
   logic [23:0] fman;
   logic [7:0]  fexp;

   always_comb begin
      ival = narrow ? {{16{req.sample_in[15]}}, req.sample_in[15:0]} : req.sample_in;
      fexp = req.sample_in[30:23];
      fman = {1'b1, req.sample_in[22:0]};
      s1_nan_in  = (fexp == 8'hFF) && (req.sample_in[22:0] != 23'd0);
      s1_big_in  = fexp >= 8'd127;
      s1_tiny_in = narrow ? (fexp < 8'd111) : (fexp < 8'd95);
      if (req.mode == afisc_pkg::MODE_I2F) begin
         s1_sign_in = ival[31];
         mag = ival[31] ? (~ival + 32'd1) : ival;
         // 16-bit scale 1/32767 in float32 is exactly 32769 * 2^-30.
         s1_prod_in = narrow ? ({mag[23:0], 15'd0} + {7'd0, mag}) : {7'd0, mag};
      end else begin
         s1_sign_in = req.sample_in[31];
         mag = 32'd0;
         s1_prod_in = narrow ? ({fman, 15'd0} - {15'd0, fman}) : {15'd0, fman};
      end
   end

   always_ff @(posedge clock) begin
      if (adv.ld1) begin
         s1_mode_ff   <= req.mode;
         s1_narrow_ff <= narrow;
         s1_last_ff   <= req.last_in;
         s1_sign_ff   <= s1_sign_in;
         s1_nan_ff    <= s1_nan_in;
         s1_big_ff    <= s1_big_in;
         s1_tiny_ff   <= s1_tiny_in;
         s1_prod_ff   <= s1_prod_in;
         s1_expo_ff   <= fexp;
      end
   end

   // ---------------- stage 2 ----------------
   logic [4:0]  lz;
   logic [8:0]  iexp;
   logic [23:0] kept;
   logic        g2, st2;
   logic [24:0] r1;
   logic [9:0]  sh10;

   always_comb begin
      lz   = afisc_pkg::lead_zeros(s1_prod_ff[31:0]);
      iexp = 9'd158 - (s1_narrow_ff ? 9'd30 : 9'd31) - {4'd0, lz};
      if (s1_prod_ff[38]) begin
         kept = s1_prod_ff[38:15];
         g2   = s1_prod_ff[14];
         st2  = |s1_prod_ff[13:0];
      end else begin
         kept = s1_prod_ff[37:14];
         g2   = s1_prod_ff[13];
         st2  = |s1_prod_ff[12:0];
      end
      r1 = {1'b0, kept} + {24'd0, g2 & (st2 | kept[0])};
      if (s1_narrow_ff) begin
         sh10 = (s1_prod_ff[38] ? 10'd135 : 10'd136) - {2'd0, s1_expo_ff};
      end else begin
         sh10 = 10'd119 - {2'd0, s1_expo_ff};
      end
      if (s1_mode_ff == afisc_pkg::MODE_I2F) begin
         s2_mant_in = s1_prod_ff[31:0] << lz;
         s2_expo_in = iexp[7:0];
      end else begin
         s2_mant_in = s1_narrow_ff ? {7'd0, r1} : {8'd0, s1_prod_ff[23:0]};
         s2_expo_in = s1_expo_ff;
      end
      s2_shift_in = sh10[6:0];
   end

   always_ff @(posedge clock) begin
      if (adv.ld2) begin
         s2_mode_ff   <= s1_mode_ff;
         s2_narrow_ff <= s1_narrow_ff;
         s2_last_ff   <= s1_last_ff;
         s2_sign_ff   <= s1_sign_ff;
         s2_nan_ff    <= s1_nan_ff;
         s2_big_ff    <= s1_big_ff;
         s2_tiny_ff   <= s1_tiny_ff;
         s2_zero_ff   <= s1_prod_ff[31:0] == 32'd0;
         s2_mant_ff   <= s2_mant_in;
         s2_expo_ff   <= s2_expo_in;
         s2_shift_ff  <= s2_shift_in;
      end
   end

   // ---------------- stage 3 ----------------
   logic [24:0] fm;
   logic [7:0]  fe;
   logic [31:0] fbits;
   logic [56:0] wide;
   logic [2:0]  lsh;
   logic [31:0] magq, val, sval;

   always_comb begin
      fm = {1'b0, s2_mant_ff[31:8]}
         + {24'd0, s2_mant_ff[7] & ((|s2_mant_ff[6:0]) | s2_mant_ff[8])};
      fe = fm[24] ? (s2_expo_ff + 8'd1) : s2_expo_ff;
      fbits = s2_zero_ff ? 32'd0
            : {s2_sign_ff, fe, (fm[24] ? 23'd0 : fm[22:0])};

      wide = {s2_mant_ff[24:0], 32'd0} >> s2_shift_ff;
      lsh  = 3'(~s2_shift_ff + 7'd1);
      if (s2_shift_ff[6]) begin
         magq = {7'd0, s2_mant_ff[24:0]} << lsh;
      end else begin
         magq = {7'd0, wide[56:32]}
              + {31'd0, wide[31] & ((|wide[30:0]) | wide[32])};
      end
      if (s2_nan_ff || (s2_tiny_ff && !s2_big_ff)) begin
         val = 32'd0;
      end else if (s2_big_ff) begin
         val = s2_narrow_ff ? afisc_pkg::MAX16 : afisc_pkg::MAX32;
      end else begin
         val = magq;
      end
      sval = s2_sign_ff ? (~val + 32'd1) : val;

      if (s2_mode_ff == afisc_pkg::MODE_I2F) begin
         s3_rsp_in.sample_out = fbits;
      end else begin
         s3_rsp_in.sample_out = s2_narrow_ff ? {16'd0, sval[15:0]} : sval;
      end
      s3_rsp_in.last_out = s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (adv.ld3) begin
         s3_rsp_ff <= s3_rsp_in;
      end
   end

   assign rsp = s3_rsp_ff;

endmodule

/* src/audio_float_int_sample_convert.sv */
// ----------------------------------------------------------------------------
// audio_float_int_sample_convert: float32 <-> signed PCM sample converter
// Pipelined converter with an APB-style register for the PCM sample width.
// ----------------------------------------------------------------------------
// An accepted input beat reaches the result port through each pipeline register.
// Throughput: one beat per cycle; the three pipeline registers each hold one
// beat, and a stalled result only blocks the stages behind it once they fill.
// Reset: synchronous, active high; clears all stage valid bits and sets the
// sample width register to signed 32-bit.
`timescale 1ns / 1ps

module audio_float_int_sample_convert (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  afisc_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output afisc_pkg::rsp_type rsp_payload,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // Sample width register: 0 selects 32-bit PCM, 1 selects 16-bit PCM.
   logic width_sel_ff, width_sel_in;

   // Valid bits travel alongside the three datapath stages.
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic rdy1, rdy2, rdy3;
   afisc_pkg::adv_type adv;

   assign csr_pready = 1'b1;

   // Register index is paddr[2]; the low byte-lane bits are not decoded.
   always_comb begin
      width_sel_in = width_sel_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == afisc_pkg::REG_WIDTH_SEL)) begin
         width_sel_in = csr_pwdata[0];
      end
      csr_prdata = (csr_paddr[2] == afisc_pkg::REG_WIDTH_SEL) ? {31'd0, width_sel_ff} : 32'd0;
   end

   // A stage may load when it is empty or when its contents move on in the
   // same cycle, so bubbles collapse and a stall loses no beat.
   always_comb begin
      rdy3 = !v3_ff || !rsp_stall;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
      adv.ld1 = rdy1;
      adv.ld2 = rdy2;
      adv.ld3 = rdy3;
      v1_in = rdy1 ? req_valid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_sel_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
      end else begin
         width_sel_ff <= width_sel_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
      end
   end

   assign req_stall = !rdy1;
   assign rsp_valid = v3_ff;

   // The datapath: decode and exact scaling, normalize or first rounding,
   // then final rounding, clipping and packing into the output register.
   afisc_pipe u_pipe (
      .clock  (clock),
      .adv    (adv),
      .req    (req_payload),
      .narrow (width_sel_ff),
      .rsp    (rsp_payload)
   );

endmodule
